/* sv/kvbp_pkg.sv */
// types, constants and helper functions shared by the budget string parser
package kvbp_pkg;

	localparam int TOKQ_DEPTH = 4;
	localparam int TOKQ_AW = $clog2(TOKQ_DEPTH);
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_AW = $clog2(RESQ_DEPTH);

	localparam int NUM_KEYS = 12;
	localparam int TIME_KEYS = 4;
	localparam logic [3:0] KEY_NONE = 4'd15;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [13:0] MILLI = 14'd1000;

	localparam logic [15:0] KEY_TABLE [NUM_KEYS] = '{
		"ts", "tu", "tr", "te", "pr", "pf", "va", "dr", "dw", "ir", "iw", "in"
	};

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_NAME,
		PH_EQ,
		PH_VALUE
	} phase_t;

	typedef enum logic [2:0] {
		ST_PAIR     = 3'd0,
		ST_DONE     = 3'd1,
		ST_SYNTAX   = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_NONDIGIT = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       ws;
		logic       eq;
		logic       digit;
		logic [3:0] dval;
		logic       last;
	} token_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  key_index;
		logic [63:0] parsed_value;
		logic [63:0] micro_value;
		logic        run_end;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} res_pair_t;

	function automatic result_t end_result(input status_t st);
		result_t r;
		r = '0;
		r.status = st;
		r.run_end = 1'b1;
		return r;
	endfunction

	function automatic result_t value_result(input logic [3:0] key, input logic bad,
			input logic [63:0] acc, input logic [63:0] micro);
		result_t r;
		if (bad) begin
			r = end_result(ST_NONDIGIT);
		end else begin
			r = '0;
			r.status = ST_PAIR;
			r.key_index = key;
			r.parsed_value = acc;
			r.micro_value = (key < 4'(TIME_KEYS)) ? micro : 64'd0;
		end
		return r;
	endfunction

	function automatic logic [3:0] key_match(input logic [15:0] name, input logic [1:0] len);
		logic [3:0] k;
		k = KEY_NONE;
		if (len == 2'd2) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				if (KEY_TABLE[i] == name) begin
					k = 4'(i);
				end
			end
		end
		return k;
	endfunction

endpackage

/* sv/key_value_budget_parser.sv */
// top level of the budget string parser: token queue, parser and result queue
// a character's token is registered in the token queue, its result in the result queue
// throughput: one character per cycle; a character closing a pair and the string
// yields two results, and the parser waits while the result queue has under two free slots
// reset: arst_n clears queues and parser state to skip-leading-whitespace
module key_value_budget_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_byte,
	input  logic        end_of_string,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [3:0]  key_index,
	output logic [63:0] parsed_value,
	output logic [63:0] micro_value,
	output logic        run_end
);
	import kvbp_pkg::*;

	logic      tok_valid;
	token_t    tok;
	logic      tok_take;
	logic      room;
	res_pair_t res;
	result_t   head;

	kvbp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.char_byte     (char_byte),
		.end_of_string (end_of_string),
		.full          (full),
		.tok_valid     (tok_valid),
		.tok           (tok),
		.tok_take      (tok_take)
	);

	kvbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_take  (tok_take),
		.room      (room),
		.res       (res)
	);

	kvbp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.room   (room),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign status = head.status;
	assign key_index = head.key_index;
	assign parsed_value = head.parsed_value;
	assign micro_value = head.micro_value;
	assign run_end = head.run_end;

endmodule

/* sv/kvbp_front.sv */
// front end: classifies incoming characters and queues them as tokens
module kvbp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      char_byte,
	input  logic            end_of_string,
	output logic            full,
	output logic            tok_valid,
	output kvbp_pkg::token_t tok,
	input  logic            tok_take
);
	import kvbp_pkg::*;

	token_t             tq_q [TOKQ_DEPTH];
	logic [TOKQ_AW-1:0] wp_q;
	logic [TOKQ_AW-1:0] rp_q;
	logic [TOKQ_AW:0]   cnt_q;
	token_t             tk_new;
	logic               do_push;
	logic               do_take;

	always_comb begin
		tk_new = '0;
		tk_new.ch = char_byte;
		if (char_byte inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			tk_new.ch = char_byte + CASE_OFFSET;
		end
		tk_new.ws = char_byte inside {[CH_TAB:CH_CR], CH_SPACE};
		tk_new.eq = (char_byte == CH_EQ);
		tk_new.digit = char_byte inside {[CH_ZERO:CH_NINE]};
		tk_new.dval = char_byte[3:0];
		tk_new.last = end_of_string;
	end

	assign full = (cnt_q == (TOKQ_AW+1)'(TOKQ_DEPTH));
	assign tok_valid = (cnt_q != '0);
	assign tok = tq_q[rp_q];
	assign do_push = push && !full;
	assign do_take = tok_take && tok_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_take) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (TOKQ_AW+1)'(do_push) - (TOKQ_AW+1)'(do_take);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			tq_q[wp_q] <= tk_new;
		end
	end

endmodule

/* sv/kvbp_back.sv */
// back end: name/value parser state, decimal accumulation and result generation
module kvbp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	input  kvbp_pkg::token_t   tok,
	output logic               tok_take,
	input  logic               room,
	output kvbp_pkg::res_pair_t res
);
	import kvbp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] name_q, name_d;
	logic [1:0]  nlen_q, nlen_d;
	logic [3:0]  key_q, key_d;
	logic [63:0] acc_q, acc_d;
	logic [63:0] micro_q, micro_d;
	logic        started_q, started_d;
	logic        bad_q, bad_d;
	logic        discard_q, discard_d;

	logic [67:0] acc_wide;
	logic [63:0] micro_next;
	logic        ovf;
	logic [1:0]  n;
	result_t     r [2];

	assign tok_take = tok_valid && room;

	// times ten by shift-add, exact overflow in the top bits
	assign acc_wide = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 68'(tok.dval);
	assign ovf = |acc_wide[67:64];
	assign micro_next = (micro_q << 3) + (micro_q << 1) + 64'(14'(tok.dval) * MILLI);

	always_comb begin
		phase_d = phase_q;
		name_d = name_q;
		nlen_d = nlen_q;
		key_d = key_q;
		acc_d = acc_q;
		micro_d = micro_q;
		started_d = started_q;
		bad_d = bad_q;
		discard_d = discard_q;
		n = 2'd0;
		r[0] = '0;
		r[1] = '0;

		if (!discard_q) begin
			case (phase_q)
				PH_SKIP: begin
					if (!tok.ws) begin
						if (tok.eq) begin
							r[n[0]] = end_result(ST_SYNTAX);
							n = n + 2'd1;
							discard_d = 1'b1;
						end else begin
							name_d = {name_q[7:0], tok.ch};
							nlen_d = 2'd1;
							phase_d = PH_NAME;
						end
					end
				end
				PH_NAME, PH_EQ: begin
					if (tok.ws) begin
						phase_d = PH_EQ;
					end else if (tok.eq) begin
						key_d = key_match(name_q, nlen_q);
						phase_d = PH_VALUE;
						started_d = 1'b0;
						bad_d = 1'b0;
						acc_d = '0;
						micro_d = '0;
					end else if (phase_q == PH_EQ) begin
						r[n[0]] = end_result(ST_SYNTAX);
						n = n + 2'd1;
						discard_d = 1'b1;
					end else begin
						if (nlen_q < 2'd2) begin
							name_d = {name_q[7:0], tok.ch};
						end
						if (nlen_q < 2'd3) begin
							nlen_d = nlen_q + 2'd1;
						end
					end
				end
				PH_VALUE: begin
					if (tok.ws) begin
						if (started_q) begin
							if (key_q < 4'(NUM_KEYS)) begin
								r[n[0]] = value_result(key_q, bad_q, acc_q, micro_q);
								n = n + 2'd1;
								discard_d = bad_q;
							end
							phase_d = PH_SKIP;
							name_d = '0;
							nlen_d = '0;
							started_d = 1'b0;
							bad_d = 1'b0;
							acc_d = '0;
							micro_d = '0;
						end
					end else begin
						started_d = 1'b1;
						if (key_q < 4'(NUM_KEYS) && !bad_q) begin
							if (tok.digit) begin
								if (ovf) begin
									r[n[0]] = end_result(ST_OVERFLOW);
									n = n + 2'd1;
									discard_d = 1'b1;
								end else begin
									acc_d = acc_wide[63:0];
									micro_d = micro_next;
								end
							end else begin
								bad_d = 1'b1;
							end
						end
					end
				end
				default: begin
					phase_d = PH_SKIP;
				end
			endcase

			if (tok.last && !discard_d) begin
				if (phase_d == PH_SKIP) begin
					r[n[0]] = end_result(ST_DONE);
					n = n + 2'd1;
				end else if (phase_d == PH_VALUE && started_d) begin
					if (key_d < 4'(NUM_KEYS)) begin
						r[n[0]] = value_result(key_d, bad_d, acc_d, micro_d);
						n = n + 2'd1;
					end
					if (!(key_d < 4'(NUM_KEYS) && bad_d)) begin
						r[n[0]] = end_result(ST_DONE);
						n = n + 2'd1;
					end
				end else begin
					r[n[0]] = end_result(ST_SYNTAX);
					n = n + 2'd1;
				end
			end
		end

		// end of string returns everything to reset
		if (tok.last) begin
			phase_d = PH_SKIP;
			name_d = '0;
			nlen_d = '0;
			key_d = '0;
			acc_d = '0;
			micro_d = '0;
			started_d = 1'b0;
			bad_d = 1'b0;
			discard_d = 1'b0;
		end
	end

	assign res.cnt = tok_take ? n : 2'd0;
	assign res.r0 = r[0];
	assign res.r1 = r[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			name_q <= '0;
			nlen_q <= '0;
			key_q <= '0;
			acc_q <= '0;
			micro_q <= '0;
			started_q <= 1'b0;
			bad_q <= 1'b0;
			discard_q <= 1'b0;
		end else if (tok_take) begin
			phase_q <= phase_d;
			name_q <= name_d;
			nlen_q <= nlen_d;
			key_q <= key_d;
			acc_q <= acc_d;
			micro_q <= micro_d;
			started_q <= started_d;
			bad_q <= bad_d;
			discard_q <= discard_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take && tok.last |=> phase_q == PH_SKIP && !discard_q && !started_q)
		else $error("end of string did not clear parser state");

	a_second_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.cnt == 2'd2 |-> res.r1.status == ST_DONE && res.r1.run_end
			&& res.r0.status == ST_PAIR)
		else $error("two results must be a pair then done");

	a_discard_silent: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take && discard_q |-> res.cnt == 2'd0)
		else $error("result produced while discarding");

	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.cnt != 2'd0 |-> res.r0.run_end == (res.r0.status != ST_PAIR))
		else $error("run_end inconsistent with status");

endmodule

/* sv/kvbp_outq.sv */
// result queue: up to two writes per cycle, one read
module kvbp_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  kvbp_pkg::res_pair_t res,
	output logic                room,
	output logic                empty,
	input  logic                pop,
	output kvbp_pkg::result_t   head
);
	import kvbp_pkg::*;

	result_t            rq_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0] wp_q;
	logic [RESQ_AW-1:0] rp_q;
	logic [RESQ_AW:0]   cnt_q;
	logic               do_pop;
	logic [RESQ_AW-1:0] wp_next;

	assign empty = (cnt_q == '0);
	assign room = (cnt_q <= (RESQ_AW+1)'(RESQ_DEPTH - 2));
	assign do_pop = pop && !empty;
	assign head = rq_q[rp_q];
	assign wp_next = wp_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + RESQ_AW'(res.cnt);
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (RESQ_AW+1)'(res.cnt) - (RESQ_AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res.cnt != 2'd0) begin
			rq_q[wp_q] <= res.r0;
		end
		if (res.cnt == 2'd2) begin
			rq_q[wp_next] <= res.r1;
		end
	end

endmodule
